[rtl/core/p256_pkg.sv]
// Package for the P-256 Montgomery field unit: request/result structs, opcodes,
// field constants and chain-sequencer encodings. No dependencies.
package p256_pkg;

    typedef struct packed {
        logic [3:0]  op;
        logic [63:0] a_w0;
        logic [63:0] a_w1;
        logic [63:0] a_w2;
        logic [63:0] a_w3;
        logic [63:0] b_w0;
        logic [63:0] b_w1;
        logic [63:0] b_w2;
        logic [63:0] b_w3;
    } req_t;

    typedef struct packed {
        logic [63:0] r_w0;
        logic [63:0] r_w1;
        logic [63:0] r_w2;
        logic [63:0] r_w3;
        logic        nonresidue;
    } rsp_t;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_NEG  = 4'd2;
    localparam logic [3:0] OP_MUL  = 4'd3;
    localparam logic [3:0] OP_TOM  = 4'd4;
    localparam logic [3:0] OP_FROM = 4'd5;
    localparam logic [3:0] OP_INV  = 4'd6;
    localparam logic [3:0] OP_LEG  = 4'd7;
    localparam logic [3:0] OP_SQRT = 4'd8;

    localparam logic [255:0] FP =
        256'hFFFFFFFF00000001000000000000000000000000FFFFFFFFFFFFFFFFFFFFFFFF;
    localparam logic [255:0] RMOD =
        256'h00000000FFFFFFFEFFFFFFFFFFFFFFFFFFFFFFFF000000000000000000000001;
    localparam logic [255:0] RSQ =
        256'h00000004FFFFFFFDFFFFFFFFFFFFFFFEFFFFFFFBFFFFFFFF0000000000000003;
    localparam logic [255:0] PINV =
        256'h00000000FFFFFFFDFFFFFFFFFFFFFFFFFFFFFFFEFFFFFFFFFFFFFFFFFFFFFFFF;

    // multiplier operand selects for one chain step
    localparam logic [2:0] SRC_X  = 3'd0;
    localparam logic [2:0] SRC_A  = 3'd1;
    localparam logic [2:0] SRC_K0 = 3'd2;
    localparam logic [2:0] SRC_K1 = 3'd3;
    localparam logic [2:0] SRC_K2 = 3'd4;
    localparam logic [2:0] SRC_K3 = 3'd5;
    localparam logic [2:0] SRC_K4 = 3'd6;

    // one chain step: square x n times, then optionally multiply by a source
    typedef struct packed {
        logic [6:0] nsq;
        logic       do_mul;
        logic [2:0] src;
        logic       save;  // store result as k[save_idx]
        logic [2:0] save_idx;
        logic       last;
    } step_t;

    function automatic step_t chain_step(input logic [4:0] idx, input logic [3:0] op);
        step_t s;
        s = '{nsq: 7'd0, do_mul: 1'b0, src: SRC_X, save: 1'b0, save_idx: 3'd0,
              last: 1'b0};
        unique case (idx)
            5'd0: s = '{7'd1,  1'b1, SRC_A,  1'b1, 3'd0, 1'b0};
            5'd1: s = '{7'd2,  1'b1, SRC_K0, 1'b1, 3'd1, 1'b0};
            5'd2: s = '{7'd4,  1'b1, SRC_K1, 1'b1, 3'd2, 1'b0};
            5'd3: s = '{7'd8,  1'b1, SRC_K2, 1'b1, 3'd3, 1'b0};
            5'd4: s = '{7'd16, 1'b1, SRC_K3, 1'b1, 3'd4, 1'b0};
            5'd5: s = '{7'd32, 1'b1, SRC_A,  1'b0, 3'd0, 1'b0};
            5'd6: s = (op == OP_SQRT) ? step_t'{7'd96, 1'b1, SRC_A, 1'b0, 3'd0, 1'b0}
                                      : step_t'{7'd96, 1'b0, SRC_X, 1'b0, 3'd0, 1'b0};
            5'd7: s = (op == OP_SQRT) ? step_t'{7'd94, 1'b0, SRC_X, 1'b0, 3'd0, 1'b1}
                                      : step_t'{7'd32, 1'b1, SRC_K4, 1'b0, 3'd0, 1'b0};
            5'd8:  s = '{7'd32, 1'b1, SRC_K4, 1'b0, 3'd0, 1'b0};
            5'd9:  s = '{7'd16, 1'b1, SRC_K3, 1'b0, 3'd0, 1'b0};
            5'd10: s = '{7'd8,  1'b1, SRC_K2, 1'b0, 3'd0, 1'b0};
            5'd11: s = '{7'd4,  1'b1, SRC_K1, 1'b0, 3'd0, 1'b0};
            5'd12: s = '{7'd2,  1'b1, SRC_K0, 1'b0, 3'd0, 1'b0};
            5'd13: s = (op == OP_INV) ? step_t'{7'd2, 1'b1, SRC_A, 1'b0, 3'd0, 1'b1}
                                      : step_t'{7'd1, 1'b1, SRC_A, 1'b0, 3'd0, 1'b1};
            default: s = '{7'd0, 1'b0, SRC_X, 1'b0, 3'd0, 1'b1};
        endcase
        return s;
    endfunction

endpackage

[rtl/core/p256_mont_mul.sv]
// Montgomery multiplier: one 64x64 word product per step, built from four
// 32x32 partial products, and a 64-bit-word accumulate; depends on p256_pkg.
module p256_mont_mul
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [255:0] x,
    input  logic [255:0] y,
    output logic         done,
    output logic [255:0] r
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_SUB  = 3'd3;
    localparam logic [2:0] S_FIX  = 3'd4;
    localparam logic [2:0] S_CMB  = 3'd5;

    // passes: 0 T=x*y, 1 W=T*PINV mod R, 2 M=W*P
    logic [2:0]   state_reg, state_next;
    logic [1:0]   pass_reg, pass_next;
    logic [1:0]   i_reg, i_next;
    logic [1:0]   j_reg, j_next;
    logic [255:0] xo_reg, xo_next, yo_reg, yo_next;
    logic [511:0] t_reg, t_next;
    logic [511:0] acc_reg, acc_next;
    logic [63:0]  pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [127:0] prod_reg;
    logic [63:0]  cy_reg, cy_next;
    logic [511:0] d_reg, d_next;
    logic         bw_reg, bw_next;
    logic [255:0] r_reg, r_next;
    logic         done_reg, done_next;

    logic [63:0]  xw, yw;
    logic [2:0]   col;
    logic [129:0] sum;
    logic [512:0] dif;

    assign xw  = xo_reg[64*i_reg +: 64];
    assign yw  = yo_reg[64*j_reg +: 64];
    assign col = {1'b0, i_reg} + {1'b0, j_reg};

    // partial products of the current word pair, then their sum
    always_ff @(posedge clk)
    begin
        pp_ll_reg <= {32'd0, xw[31:0]} * {32'd0, yw[31:0]};
        pp_lh_reg <= {32'd0, xw[31:0]} * {32'd0, yw[63:32]};
        pp_hl_reg <= {32'd0, xw[63:32]} * {32'd0, yw[31:0]};
        pp_hh_reg <= {32'd0, xw[63:32]} * {32'd0, yw[63:32]};
        prod_reg  <= {pp_hh_reg, pp_ll_reg} + {32'd0, pp_lh_reg, 32'd0}
                     + {32'd0, pp_hl_reg, 32'd0};
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        xo_next    = xo_reg;
        yo_next    = yo_reg;
        t_next     = t_reg;
        acc_next   = acc_reg;
        cy_next    = cy_reg;
        d_next     = d_reg;
        bw_next    = bw_reg;
        r_next     = r_reg;
        done_next  = 1'b0;
        sum        = '0;
        dif        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    xo_next    = x;
                    yo_next    = y;
                    pass_next  = 2'd0;
                    i_next     = '0;
                    j_next     = '0;
                    acc_next   = '0;
                    cy_next    = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
                state_next = S_CMB;
            S_CMB:
                state_next = S_ACC;
            S_ACC:
            begin
                // word add of the full product, accumulator column and carry word
                sum = {66'd0, acc_reg[64*col +: 64]} + {2'd0, prod_reg}
                      + {66'd0, cy_reg};
                acc_next[64*col +: 64] = sum[63:0];
                cy_next = sum[127:64];
                state_next = S_MUL;
                if (pass_reg == 2'd1 && j_reg == 2'd3 - i_reg)
                begin
                    // low half only for mod R product
                    cy_next = '0;
                    j_next  = '0;
                    if (i_reg == 2'd3)
                    begin
                        xo_next   = acc_next[255:0];
                        yo_next   = p256_pkg::FP;
                        acc_next  = '0;
                        pass_next = 2'd2;
                        i_next    = '0;
                    end
                    else
                        i_next = i_reg + 2'd1;
                end
                else if (j_reg == 2'd3)
                begin
                    acc_next[64*({1'b0, i_reg} + 3'd4) +: 64] = sum[127:64];
                    cy_next = '0;
                    j_next  = '0;
                    if (i_reg == 2'd3)
                    begin
                        i_next = '0;
                        if (pass_reg == 2'd0)
                        begin
                            t_next    = acc_next;
                            xo_next   = acc_next[255:0];
                            yo_next   = p256_pkg::PINV;
                            acc_next  = '0;
                            pass_next = 2'd1;
                        end
                        else
                            state_next = S_SUB;
                    end
                    else
                        i_next = i_reg + 2'd1;
                end
                else
                    j_next = j_reg + 2'd1;
            end
            S_SUB:
            begin
                dif        = {1'b0, t_reg} - {1'b0, acc_reg};
                d_next     = dif[511:0];
                bw_next    = dif[512];
                state_next = S_FIX;
            end
            S_FIX:
            begin
                r_next     = d_reg[511:256] + (bw_reg ? p256_pkg::FP : 256'd0);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg <= pass_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        xo_reg   <= xo_next;
        yo_reg   <= yo_next;
        t_reg    <= t_next;
        acc_reg  <= acc_next;
        cy_reg   <= cy_next;
        d_reg    <= d_next;
        bw_reg   <= bw_next;
        r_reg    <= r_next;
    end

    assign done = done_reg;
    assign r    = r_reg;

endmodule

[rtl/core/p256_montgomery_field_unit.sv]
// Top level of the P-256 Montgomery field unit: request decode, add/sub path
// and the exponent-chain sequencer; uses p256_pkg and p256_mont_mul.
//
// Usage: drive req and raise start while busy is low; the request is taken on
// that edge and busy is high from the next cycle. The result sits on rsp for
// exactly one cycle with valid high; busy falls in that same cycle, so the next
// request can be taken at the edge that ends it. The receiver cannot stall; a
// result not taken on its cycle is gone.
// Add, sub and neg pass through a fold step before the result; undefined opcodes
// skip it and return zero. One Montgomery multiply runs three schoolbook passes
// of 16, 10 and 16 word products, each product going through partial products,
// combine and accumulate, plus start, subtract, fix-up and handoff. mul, to_mont
// and the conversion back out of Montgomery form use one multiply; sqrt chains
// 260 multiplies, legendre 267 and inverse 268. A new request is taken only
// after busy has fallen.
// Reset clears the sequencer; no request is in flight after reset.
module p256_montgomery_field_unit
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  p256_pkg::req_t   req,
    output logic             busy,
    output logic             valid,
    output p256_pkg::rsp_t   rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_FOLD = 3'd2;
    localparam logic [2:0] S_MMUL = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic [3:0]   op_reg;
    logic [255:0] a_reg, b_reg, x_reg, x_next;
    logic [255:0] k_reg [5];
    logic [4:0]   step_reg, step_next;
    logic [6:0]   sq_reg, sq_next;
    logic         mphase_reg, mphase_next; // 1: multiply by source, 0: square
    logic         chain_reg;
    logic         busy_reg, valid_reg;
    p256_pkg::rsp_t rsp_reg;

    p256_pkg::step_t st;
    logic         mstart, mdone;
    logic [255:0] mx, my, mr, src_val;
    logic [256:0] s1, s2;
    logic [255:0] addr;

    assign st = p256_pkg::chain_step(step_reg, op_reg);

    always_comb
    begin
        case (st.src)
            p256_pkg::SRC_A:  src_val = a_reg;
            p256_pkg::SRC_K0: src_val = k_reg[0];
            p256_pkg::SRC_K1: src_val = k_reg[1];
            p256_pkg::SRC_K2: src_val = k_reg[2];
            p256_pkg::SRC_K3: src_val = k_reg[3];
            p256_pkg::SRC_K4: src_val = k_reg[4];
            default:          src_val = x_reg;
        endcase
    end

    assign mx = x_reg;
    assign my = chain_reg ? (mphase_reg ? src_val : x_reg) : b_reg;
    assign mstart = (state_reg == S_MMUL);

    p256_mont_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mstart),
        .x     (mx),
        .y     (my),
        .done  (mdone),
        .r     (mr)
    );

    // add/sub with wrap by R mod p on carry or borrow; neg as p minus a
    always_comb
    begin
        s1   = '0;
        s2   = '0;
        addr = '0;
        case (op_reg)
            p256_pkg::OP_ADD:
            begin
                s1   = {1'b0, a_reg} + {1'b0, b_reg};
                addr = s1[255:0] + (s1[256] ? p256_pkg::RMOD : 256'd0);
            end
            p256_pkg::OP_SUB:
            begin
                s1   = {1'b0, a_reg} - {1'b0, b_reg};
                addr = s1[255:0] - (s1[256] ? p256_pkg::RMOD : 256'd0);
            end
            default:
                addr = p256_pkg::FP - a_reg;
        endcase
        s2 = {1'b0, x_reg} - {1'b0, p256_pkg::FP};
    end

    always_comb
    begin
        state_next  = state_reg;
        x_next      = x_reg;
        step_next   = step_reg;
        sq_next     = sq_reg;
        mphase_next = mphase_reg;
        unique case (state_reg)
            S_IDLE:
                if (start && !busy_reg)
                    state_next = S_ADD;
            S_ADD:
            begin
                state_next = S_DONE;
                x_next     = '0;
                unique case (op_reg) inside
                    p256_pkg::OP_ADD, p256_pkg::OP_SUB, p256_pkg::OP_NEG:
                    begin
                        x_next     = addr;
                        state_next = S_FOLD;
                    end
                    p256_pkg::OP_MUL, p256_pkg::OP_TOM, p256_pkg::OP_FROM:
                    begin
                        x_next     = a_reg;
                        state_next = S_MMUL;
                    end
                    p256_pkg::OP_INV, p256_pkg::OP_LEG, p256_pkg::OP_SQRT:
                    begin
                        x_next      = a_reg;
                        step_next   = '0;
                        sq_next     = 7'd1;
                        mphase_next = 1'b0;
                        state_next  = S_MMUL;
                    end
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_FOLD:
            begin
                if (!s2[256])
                    x_next = s2[255:0];
                state_next = S_DONE;
            end
            S_MMUL:
                state_next = S_WAIT;
            S_WAIT:
                if (mdone)
                begin
                    x_next = mr;
                    if (!chain_reg)
                        state_next = S_DONE;
                    else if (!mphase_reg && sq_reg != st.nsq)
                    begin
                        sq_next    = sq_reg + 7'd1;
                        state_next = S_MMUL;
                    end
                    else if (!mphase_reg && st.do_mul)
                    begin
                        mphase_next = 1'b1;
                        state_next  = S_MMUL;
                    end
                    else if (st.last)
                        state_next = S_DONE;
                    else
                    begin
                        step_next   = step_reg + 5'd1;
                        sq_next     = 7'd1;
                        mphase_next = 1'b0;
                        state_next  = S_MMUL;
                    end
                end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            valid_reg <= (state_reg == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start && !busy_reg)
        begin
            op_reg    <= req.op;
            a_reg     <= {req.a_w3, req.a_w2, req.a_w1, req.a_w0};
            chain_reg <= (req.op == p256_pkg::OP_INV) || (req.op == p256_pkg::OP_LEG)
                         || (req.op == p256_pkg::OP_SQRT);
            case (req.op)
                p256_pkg::OP_TOM:  b_reg <= p256_pkg::RSQ;
                p256_pkg::OP_FROM: b_reg <= 256'd1;
                default:           b_reg <= {req.b_w3, req.b_w2, req.b_w1, req.b_w0};
            endcase
        end
        x_reg      <= x_next;
        step_reg   <= step_next;
        sq_reg     <= sq_next;
        mphase_reg <= mphase_next;
        // save run value after the multiply of a head step
        if (state_reg == S_WAIT && mdone && chain_reg && mphase_reg && st.save)
            k_reg[st.save_idx] <= mr;
        if (state_reg == S_DONE)
        begin
            if (op_reg == p256_pkg::OP_LEG)
            begin
                rsp_reg.r_w0       <= '0;
                rsp_reg.r_w1       <= '0;
                rsp_reg.r_w2       <= '0;
                rsp_reg.r_w3       <= '0;
                rsp_reg.nonresidue <= x_reg[1];
            end
            else
            begin
                rsp_reg.r_w0       <= x_reg[63:0];
                rsp_reg.r_w1       <= x_reg[127:64];
                rsp_reg.r_w2       <= x_reg[191:128];
                rsp_reg.r_w3       <= x_reg[255:192];
                rsp_reg.nonresidue <= 1'b0;
            end
        end
    end

    assign busy  = busy_reg;
    assign valid = valid_reg;
    assign rsp   = rsp_reg;

endmodule

[dv/p256_montgomery_field_unit_tb.sv]
// Self-checking bench for the P-256 Montgomery field unit: drives opcode/operand
// requests, predicts each result with a local bit-exact model, compares field by field.
// Depends on p256_pkg and p256_montgomery_field_unit.
module p256_montgomery_field_unit_tb;

    typedef logic [255:0] fe_t;
    typedef logic [511:0] wide_t;

    logic clk;
    logic rst_n;
    logic start;
    p256_pkg::req_t req;
    logic busy;
    logic valid;
    p256_pkg::rsp_t rsp;

    p256_pkg::req_t pending_reqs[$];
    p256_pkg::rsp_t expected_rsps[$];
    int   n_errors = 0;
    int   idle_left;
    int   quiet_cycles;
    bit   no_idle;
    bit   drain_hold;

    localparam int WATCHDOG_LIMIT = 200000;

    p256_montgomery_field_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .valid (valid),
        .rsp   (rsp)
    );

    always #6 clk = ~clk;

    // REDC exactly as the datapath does it: one conditional add of p on borrow
    function automatic fe_t redc(input wide_t t);
        wide_t q;
        wide_t m;
        logic [512:0] d;
        q = wide_t'(t[255:0]) * wide_t'(p256_pkg::PINV);
        m = wide_t'(q[255:0]) * wide_t'(p256_pkg::FP);
        d = {1'b0, t} - {1'b0, m};
        return d[511:256] + (d[512] ? p256_pkg::FP : 256'd0);
    endfunction

    function automatic fe_t mont_mul(input fe_t x, input fe_t y);
        return redc(wide_t'(x) * wide_t'(y));
    endfunction

    function automatic fe_t square_n(input fe_t x, input int n);
        for (int i = 0; i < n; i++)
            x = mont_mul(x, x);
        return x;
    endfunction

    // subtract p once; keep the original if that borrows
    function automatic fe_t fold_p(input fe_t x);
        logic [256:0] d;
        d = {1'b0, x} - {1'b0, p256_pkg::FP};
        return d[256] ? x : d[255:0];
    endfunction

    function automatic p256_pkg::rsp_t predict_field_op(input p256_pkg::req_t r);
        fe_t a;
        fe_t b;
        fe_t x;
        fe_t run;
        fe_t ones[5];
        logic [256:0] s;
        p256_pkg::rsp_t o;
        a = {r.a_w3, r.a_w2, r.a_w1, r.a_w0};
        b = {r.b_w3, r.b_w2, r.b_w1, r.b_w0};
        x = '0;
        o = '0;
        if (r.op == p256_pkg::OP_INV || r.op == p256_pkg::OP_LEG
            || r.op == p256_pkg::OP_SQRT)
        begin
            x = a;
            run = a;
            for (int j = 0; j < 5; j++)
            begin
                x = mont_mul(square_n(x, 1 << j), run);
                ones[j] = x;
                run = x;
            end
            x = mont_mul(square_n(x, 32), a);
            x = square_n(x, 96);
            if (r.op == p256_pkg::OP_SQRT)
            begin
                x = square_n(mont_mul(x, a), 94);
            end
            else
            begin
                x = mont_mul(square_n(x, 32), ones[4]);
                x = mont_mul(square_n(x, 32), ones[4]);
                x = mont_mul(square_n(x, 16), ones[3]);
                x = mont_mul(square_n(x, 8), ones[2]);
                x = mont_mul(square_n(x, 4), ones[1]);
                x = mont_mul(square_n(x, 2), ones[0]);
                x = mont_mul(square_n(x, (r.op == p256_pkg::OP_INV) ? 2 : 1), a);
            end
        end
        case (r.op) inside
            p256_pkg::OP_ADD:
            begin
                s = {1'b0, a} + {1'b0, b};
                x = fold_p(s[255:0] + (s[256] ? p256_pkg::RMOD : 256'd0));
            end
            p256_pkg::OP_SUB:
            begin
                s = {1'b0, a} - {1'b0, b};
                x = fold_p(s[255:0] - (s[256] ? p256_pkg::RMOD : 256'd0));
            end
            p256_pkg::OP_NEG:  x = fold_p(p256_pkg::FP - a);
            p256_pkg::OP_MUL:  x = mont_mul(a, b);
            p256_pkg::OP_TOM:  x = mont_mul(a, p256_pkg::RSQ);
            p256_pkg::OP_FROM: x = redc(wide_t'(a));
            p256_pkg::OP_LEG:
            begin
                o.nonresidue = x[1];
                x = '0;
            end
            p256_pkg::OP_INV, p256_pkg::OP_SQRT: ;
            default: x = '0;
        endcase
        {o.r_w3, o.r_w2, o.r_w1, o.r_w0} = x;
        return o;
    endfunction

    function automatic fe_t rand_fe();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    // mostly reduced operands, with edge values and occasional unreduced ones
    function automatic fe_t pick_operand();
        fe_t v;
        v = rand_fe();
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = p256_pkg::FP - 256'd1;
            2: v = v & 256'hF;
            3: ;
            default:
                if (v >= p256_pkg::FP)
                    v = v - p256_pkg::FP;
        endcase
        return v;
    endfunction

    function automatic p256_pkg::req_t make_req(input logic [3:0] op, input fe_t a,
                                                input fe_t b);
        p256_pkg::req_t r;
        r.op = op;
        {r.a_w3, r.a_w2, r.a_w1, r.a_w0} = a;
        {r.b_w3, r.b_w2, r.b_w1, r.b_w0} = b;
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            req       <= '0;
            idle_left <= 0;
        end
        else if (start && !busy)
        begin
            // request taken at this edge
            start <= 1'b0;
            expected_rsps.push_back(predict_field_op(req));
            if (!no_idle && $urandom_range(0, 2) == 0)
                idle_left <= $urandom_range(1, 11);
        end
        else if (!start)
        begin
            if (idle_left > 0)
                idle_left <= idle_left - 1;
            else if (pending_reqs.size() > 0 && !(drain_hold && expected_rsps.size() > 0))
            begin
                req   <= pending_reqs.pop_front();
                start <= 1'b1;
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if ((start && !busy) || valid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (valid)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("result with no request outstanding");
                    n_errors++;
                end
                else
                begin
                    p256_pkg::rsp_t e;
                    e = expected_rsps.pop_front();
                    if (rsp.r_w0 !== e.r_w0)
                    begin
                        $error("r_w0 exp %h got %h", e.r_w0, rsp.r_w0);
                        n_errors++;
                    end
                    if (rsp.r_w1 !== e.r_w1)
                    begin
                        $error("r_w1 exp %h got %h", e.r_w1, rsp.r_w1);
                        n_errors++;
                    end
                    if (rsp.r_w2 !== e.r_w2)
                    begin
                        $error("r_w2 exp %h got %h", e.r_w2, rsp.r_w2);
                        n_errors++;
                    end
                    if (rsp.r_w3 !== e.r_w3)
                    begin
                        $error("r_w3 exp %h got %h", e.r_w3, rsp.r_w3);
                        n_errors++;
                    end
                    if (rsp.nonresidue !== e.nonresidue)
                    begin
                        $error("nonresidue exp %b got %b", e.nonresidue, rsp.nonresidue);
                        n_errors++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("p256_montgomery_field_unit_tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        fe_t a;
        fe_t b;
        logic [3:0] op;
        clk = 1'b0;
        rst_n = 1'b0;
        no_idle = 1'b0;
        drain_hold = 1'b0;
        // directed: extremes, every opcode, undefined codes, zero into chains
        pending_reqs.push_back(make_req(p256_pkg::OP_ADD, p256_pkg::FP - 256'd1,
                                        p256_pkg::FP - 256'd1));
        pending_reqs.push_back(make_req(p256_pkg::OP_ADD, ~256'd0, ~256'd0));
        pending_reqs.push_back(make_req(p256_pkg::OP_ADD, '0, '0));
        pending_reqs.push_back(make_req(p256_pkg::OP_SUB, '0, p256_pkg::FP - 256'd1));
        pending_reqs.push_back(make_req(p256_pkg::OP_SUB, '0, ~256'd0));
        pending_reqs.push_back(make_req(p256_pkg::OP_SUB, ~256'd0, '0));
        pending_reqs.push_back(make_req(p256_pkg::OP_NEG, '0, ~256'd0));
        pending_reqs.push_back(make_req(p256_pkg::OP_NEG, ~256'd0, '0));
        pending_reqs.push_back(make_req(p256_pkg::OP_MUL, ~256'd0, ~256'd0));
        pending_reqs.push_back(make_req(p256_pkg::OP_MUL, p256_pkg::RMOD,
                                        p256_pkg::FP - 256'd1));
        pending_reqs.push_back(make_req(p256_pkg::OP_TOM, p256_pkg::FP - 256'd1, '0));
        pending_reqs.push_back(make_req(p256_pkg::OP_FROM, ~256'd0, '0));
        pending_reqs.push_back(make_req(p256_pkg::OP_FROM, p256_pkg::RMOD, '0));
        pending_reqs.push_back(make_req(p256_pkg::OP_INV, '0, '0));
        pending_reqs.push_back(make_req(p256_pkg::OP_INV, p256_pkg::RMOD, '0));
        pending_reqs.push_back(make_req(p256_pkg::OP_LEG, '0, '0));
        pending_reqs.push_back(make_req(p256_pkg::OP_LEG,
                                        p256_pkg::FP - p256_pkg::RMOD, '0));
        pending_reqs.push_back(make_req(p256_pkg::OP_LEG, p256_pkg::RSQ, '0));
        pending_reqs.push_back(make_req(p256_pkg::OP_SQRT, '0, '0));
        pending_reqs.push_back(make_req(p256_pkg::OP_SQRT, p256_pkg::RSQ, '0));
        pending_reqs.push_back(make_req(4'd9, ~256'd0, ~256'd0));
        pending_reqs.push_back(make_req(4'd15, ~256'd0, ~256'd0));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // random: cheap ops dominate, chain ops a handful since each runs a long multiply chain
        for (int n = 0; n < 78; n++)
        begin
            case ($urandom_range(0, 19)) inside
                [0:3]:   op = p256_pkg::OP_ADD;
                [4:6]:   op = p256_pkg::OP_SUB;
                [7:8]:   op = p256_pkg::OP_NEG;
                [9:12]:  op = p256_pkg::OP_MUL;
                [13:14]: op = p256_pkg::OP_TOM;
                [15:16]: op = p256_pkg::OP_FROM;
                17:      op = 4'($urandom_range(9, 15));
                default: op = 4'($urandom_range(6, 8));
            endcase
            a = pick_operand();
            b = pick_operand();
            pending_reqs.push_back(make_req(op, a, b));
        end
        wait (pending_reqs.size() <= 60);
        // hold the sender until everything outstanding has returned
        @(posedge clk);
        drain_hold <= 1'b1;
        wait (pending_reqs.size() <= 40);
        @(posedge clk);
        drain_hold <= 1'b0;
        no_idle <= 1'b1;
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0);
        repeat (50) @(posedge clk);
        if (n_errors == 0 && expected_rsps.size() == 0)
            $display("p256_montgomery_field_unit_tb: done, clean");
        else
            $display("p256_montgomery_field_unit_tb: done, errors");
        $finish;
    end

endmodule
